### src/sav_pkg.sv
// Shared types and constants for the slot allocator with value store.
package sav_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int CHUNK     = 8;
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 8;
    localparam int VAL_W     = 64;
    localparam int GRANT_W   = 6;
    localparam int STAT_W    = 2;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OUT_OF_SLOTS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID_SLOT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_READ
    } t_state;

    typedef enum logic [2:0] {
        RES_GRANT,
        RES_OOS,
        RES_INV,
        RES_OK,
        RES_READ
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     mem_wr;
        logic     mem_rd;
        logic     set_free;
        logic     claim;
        logic     scan_next;
        logic     emit;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              idx_ok;
        logic              hit;
        logic              last;
    } t_stat;

endpackage

### src/slot_allocator_value_store_top.sv
// Top level of the slot allocator with value store.
//
//  Channel  | Handshake            | Word
//  request  | start, busy          | i_mode, i_slot_index, i_write_value
//  result   | o_strobe (one cycle) | o_granted_slot, o_read_value, o_status
//
// A request word is taken when start is high and busy is low.
// Free, write and invalid-slot results go from EXEC to the result registers; read results
// pass through READ first because the value memory has a registered read port.
// Allocate scans the free map eight slots per cycle in SCAN, chunk by chunk from chunk 0,
// up to the first free slot or the last of ceil(SLOTS/8) chunks.
// Busy drops in the cycle the result is shown, so the next request may enter then.
// Reset is synchronous and active low; the receiver cannot stall the result.
module slot_allocator_value_store_top #(
    parameter int SLOTS = sav_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sav_pkg::MODE_W-1:0]   i_mode,
    input  logic [sav_pkg::IDX_W-1:0]    i_slot_index,
    input  logic [sav_pkg::VAL_W-1:0]    i_write_value,
    output logic                         o_strobe,
    output logic [sav_pkg::GRANT_W-1:0]  o_granted_slot,
    output logic [sav_pkg::VAL_W-1:0]    o_read_value,
    output logic [sav_pkg::STAT_W-1:0]   o_status
);

    sav_pkg::t_cmd  cmd;
    sav_pkg::t_stat stat;

    sav_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    sav_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .i_write_value  (i_write_value),
        .o_strobe       (o_strobe),
        .o_granted_slot (o_granted_slot),
        .o_read_value   (o_read_value),
        .o_status       (o_status)
    );

endmodule

### src/sav_ctrl.sv
// Controller state machine that sequences each request word through the datapath.
module sav_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sav_pkg::t_stat i_stat,
    output sav_pkg::t_cmd  o_cmd,
    output logic           busy
);

    sav_pkg::t_state r_state;
    sav_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sav_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_sel = sav_pkg::RES_OK;
        case (r_state)
            sav_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = sav_pkg::ST_EXEC;
                end
            end
            sav_pkg::ST_EXEC: begin
                if (i_stat.mode == sav_pkg::MODE_ALLOC) begin
                    n_state = sav_pkg::ST_SCAN;
                end else if (!i_stat.idx_ok) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = sav_pkg::RES_INV;
                    n_state       = sav_pkg::ST_IDLE;
                end else if (i_stat.mode == sav_pkg::MODE_READ) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = sav_pkg::ST_READ;
                end else begin
                    o_cmd.set_free = (i_stat.mode == sav_pkg::MODE_FREE);
                    o_cmd.mem_wr   = (i_stat.mode == sav_pkg::MODE_WRITE);
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_sel  = sav_pkg::RES_OK;
                    n_state        = sav_pkg::ST_IDLE;
                end
            end
            sav_pkg::ST_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.claim   = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = sav_pkg::RES_GRANT;
                    n_state       = sav_pkg::ST_IDLE;
                end else if (i_stat.last) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = sav_pkg::RES_OOS;
                    n_state       = sav_pkg::ST_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            sav_pkg::ST_READ: begin
                o_cmd.emit    = 1'b1;
                o_cmd.res_sel = sav_pkg::RES_READ;
                n_state       = sav_pkg::ST_IDLE;
            end
            default: begin
                n_state = sav_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != sav_pkg::ST_IDLE);

endmodule

### src/sav_dpath.sv
// Datapath holding the free map, chunked first-fit scanner, value memory and result registers.
module sav_dpath #(
    parameter int SLOTS = sav_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sav_pkg::t_cmd                i_cmd,
    output sav_pkg::t_stat               o_stat,
    input  logic [sav_pkg::MODE_W-1:0]   i_mode,
    input  logic [sav_pkg::IDX_W-1:0]    i_slot_index,
    input  logic [sav_pkg::VAL_W-1:0]    i_write_value,
    output logic                         o_strobe,
    output logic [sav_pkg::GRANT_W-1:0]  o_granted_slot,
    output logic [sav_pkg::VAL_W-1:0]    o_read_value,
    output logic [sav_pkg::STAT_W-1:0]   o_status
);

    localparam int IW   = $clog2(SLOTS);
    localparam int NCH  = (SLOTS + sav_pkg::CHUNK - 1) / sav_pkg::CHUNK;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int NPAD = 1 << CW;
    localparam int LW   = $clog2(sav_pkg::CHUNK);
    localparam int SW   = CW + LW;

    logic [sav_pkg::MODE_W-1:0]  r_mode;
    logic [sav_pkg::IDX_W-1:0]   r_idx;
    logic [sav_pkg::VAL_W-1:0]   r_wval;
    logic [SLOTS-1:0]            r_free;
    logic [SLOTS-1:0]            r_written;
    logic [CW-1:0]               r_chunk;
    logic [sav_pkg::VAL_W-1:0]   r_mem [SLOTS];
    logic [sav_pkg::VAL_W-1:0]   r_rdata;
    logic                        r_rvalid;
    logic                        r_strobe;
    logic [sav_pkg::GRANT_W-1:0] r_granted;
    logic [sav_pkg::VAL_W-1:0]   r_rvalue;
    logic [sav_pkg::STAT_W-1:0]  r_status;

    logic [NPAD*sav_pkg::CHUNK-1:0] free_pad;
    logic [sav_pkg::CHUNK-1:0]      chunk_bits;
    logic [LW-1:0]                  low_sel;
    logic                           hit;
    logic [SW-1:0]                  slot_full;
    logic [IW-1:0]                  addr;

    assign addr = r_idx[IW-1:0];

    // Slot 0 is never handed out, so its bit is hidden from the scanner.
    always_comb begin
        free_pad = '0;
        free_pad[SLOTS-1:0] = r_free;
        free_pad[0] = 1'b0;
    end

    assign chunk_bits = free_pad[r_chunk*sav_pkg::CHUNK +: sav_pkg::CHUNK];

    always_comb begin
        hit     = 1'b0;
        low_sel = '0;
        for (int k = sav_pkg::CHUNK - 1; k >= 0; k--) begin
            if (chunk_bits[k]) begin
                hit     = 1'b1;
                low_sel = LW'(k);
            end
        end
    end

    assign slot_full = {r_chunk, low_sel};

    assign o_stat.mode   = r_mode;
    assign o_stat.idx_ok = ({1'b0, r_idx} < (sav_pkg::IDX_W + 1)'(SLOTS));
    assign o_stat.hit    = hit;
    assign o_stat.last   = (r_chunk == CW'(NCH - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_idx  <= i_slot_index;
            r_wval <= i_write_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_cmd.load) begin
            r_chunk <= '0;
        end else if (i_cmd.scan_next) begin
            r_chunk <= r_chunk + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else if (i_cmd.claim) begin
            r_free[IW'(slot_full)] <= 1'b0;
        end else if (i_cmd.set_free) begin
            r_free[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_cmd.mem_wr) begin
            r_written[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[addr] <= r_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata  <= r_mem[addr];
            r_rvalid <= r_written[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_granted <= '0;
            r_rvalue  <= '0;
            r_status  <= sav_pkg::STAT_OK;
            case (i_cmd.res_sel)
                sav_pkg::RES_GRANT: begin
                    r_granted <= sav_pkg::GRANT_W'(slot_full);
                end
                sav_pkg::RES_OOS: begin
                    r_status <= sav_pkg::STAT_OUT_OF_SLOTS;
                end
                sav_pkg::RES_INV: begin
                    r_status <= sav_pkg::STAT_INVALID_SLOT;
                end
                sav_pkg::RES_READ: begin
                    r_rvalue <= r_rvalid ? r_rdata : '0;
                end
                default: begin
                    r_status <= sav_pkg::STAT_OK;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_granted_slot = r_granted;
    assign o_read_value   = r_rvalue;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("Result strobe held for two cycles.");
    a_oos_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == sav_pkg::STAT_OUT_OF_SLOTS) |-> (r_granted == '0))
        else $error("Out-of-slots result carries a granted slot.");
    a_err_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status != sav_pkg::STAT_OK) |-> (r_rvalue == '0))
        else $error("Failed request returned a read value.");
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |-> (hit && slot_full != '0))
        else $error("Claim issued without a free slot.");
`endif

endmodule

### tb/sv/slot_allocator_value_store_checker.sv
// Checker that predicts and compares the result words of the slot allocator.
module slot_allocator_value_store_checker #(
    parameter int SLOTS = sav_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [sav_pkg::MODE_W-1:0]   i_mode,
    input  logic [sav_pkg::IDX_W-1:0]    i_slot_index,
    input  logic [sav_pkg::VAL_W-1:0]    i_write_value,
    input  logic                         i_strobe,
    input  logic [sav_pkg::GRANT_W-1:0]  i_granted_slot,
    input  logic [sav_pkg::VAL_W-1:0]    i_read_value,
    input  logic [sav_pkg::STAT_W-1:0]   i_status,
    output int                           o_pending,
    output int                           o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sav_pkg::GRANT_W-1:0] slot;
        logic [sav_pkg::VAL_W-1:0]   rdata;
        logic [sav_pkg::STAT_W-1:0]  status;
    } t_slot_result;

    logic                       slot_free [SLOTS];
    logic [sav_pkg::VAL_W-1:0]  slot_value [SLOTS];
    t_slot_result               expected_words [$];
    int                         mismatch_count;

    function automatic t_slot_result apply_request(input logic [sav_pkg::MODE_W-1:0] mode,
                                                   input logic [sav_pkg::IDX_W-1:0]  idx,
                                                   input logic [sav_pkg::VAL_W-1:0]  wval);
        t_slot_result r;
        logic         found;
        r = '0;
        found = 1'b0;
        r.status = sav_pkg::STAT_OK;
        if (mode == sav_pkg::MODE_ALLOC) begin
            r.status = sav_pkg::STAT_OUT_OF_SLOTS;
            for (int s = 1; s < SLOTS; s++) begin
                if (!found && slot_free[s]) begin
                    found = 1'b1;
                    slot_free[s] = 1'b0;
                    r.slot = sav_pkg::GRANT_W'(s);
                    r.status = sav_pkg::STAT_OK;
                end
            end
        end else if (int'(idx) >= SLOTS) begin
            r.status = sav_pkg::STAT_INVALID_SLOT;
        end else if (mode == sav_pkg::MODE_FREE) begin
            slot_free[idx] = 1'b1;
        end else if (mode == sav_pkg::MODE_READ) begin
            r.rdata = slot_value[idx];
        end else begin
            slot_value[idx] = wval;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_slot_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_free[s] = 1'b1;
                slot_value[s] = '0;
            end
            expected_words.delete();
        end else begin
            if (i_strobe) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_granted_slot !== want.slot) begin
                        $error("granted_slot expected %0d actual %0d", want.slot, i_granted_slot);
                        mismatch_count++;
                    end
                    if (i_read_value !== want.rdata) begin
                        $error("read_value expected %h actual %h", want.rdata, i_read_value);
                        mismatch_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, i_status);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_words.push_back(apply_request(i_mode, i_slot_index, i_write_value));
            end
        end
        o_pending <= expected_words.size();
        o_errors <= mismatch_count;
    end

endmodule

### tb/sv/testbench.sv
// Top of the testbench: clock, reset, request stimulus and the final verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = sav_pkg::SLOTS_DEF;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [sav_pkg::MODE_W-1:0]   i_mode;
    logic [sav_pkg::IDX_W-1:0]    i_slot_index;
    logic [sav_pkg::VAL_W-1:0]    i_write_value;
    logic                         o_strobe;
    logic [sav_pkg::GRANT_W-1:0]  o_granted_slot;
    logic [sav_pkg::VAL_W-1:0]    o_read_value;
    logic [sav_pkg::STAT_W-1:0]   o_status;
    int                           words_pending;
    int                           error_count;
    int                           gap_percent;
    int                           words_sent;

    slot_allocator_value_store_top #(.SLOTS(SLOTS)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .i_write_value  (i_write_value),
        .o_strobe       (o_strobe),
        .o_granted_slot (o_granted_slot),
        .o_read_value   (o_read_value),
        .o_status       (o_status)
    );

    slot_allocator_value_store_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .i_write_value  (i_write_value),
        .i_strobe       (o_strobe),
        .i_granted_slot (o_granted_slot),
        .i_read_value   (o_read_value),
        .i_status       (o_status),
        .o_pending      (words_pending),
        .o_errors       (error_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL slot_allocator_value_store_top");
        $finish;
    end

    // Start stays high from one accepted word to the next unless a gap is inserted.
    task automatic send_word(input logic [sav_pkg::MODE_W-1:0] mode,
                             input logic [sav_pkg::IDX_W-1:0] idx,
                             input logic [sav_pkg::VAL_W-1:0] val);
        if ($urandom_range(0, 99) < gap_percent) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_slot_index <= idx;
        i_write_value <= val;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    function automatic logic [sav_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return sav_pkg::VAL_W'(1) << $urandom_range(0, sav_pkg::VAL_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [sav_pkg::IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '1;
        if (r < 12) return sav_pkg::IDX_W'($urandom_range(SLOTS, 255));
        if (r < 55) return sav_pkg::IDX_W'($urandom_range(0, 15));
        return sav_pkg::IDX_W'($urandom_range(0, SLOTS - 1));
    endfunction

    task automatic send_burst(input int alloc_w, input int free_w, input int read_w,
                              input int len);
        int r;
        logic [sav_pkg::MODE_W-1:0] mode;
        for (int n = 0; n < len; n++) begin
            r = $urandom_range(0, 99);
            if (r < alloc_w) mode = sav_pkg::MODE_ALLOC;
            else if (r < alloc_w + free_w) mode = sav_pkg::MODE_FREE;
            else if (r < alloc_w + free_w + read_w) mode = sav_pkg::MODE_READ;
            else mode = sav_pkg::MODE_WRITE;
            send_word(mode, pick_index(), pick_value());
        end
    endtask

    initial begin
        int phase_gap [4];
        phase_gap = '{0, 81, 0, 8};
        gap_percent = 0;
        words_sent = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_mode <= sav_pkg::MODE_ALLOC;
        i_slot_index <= '0;
        i_write_value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(sav_pkg::MODE_READ,  8'd0,   '0);
        send_word(sav_pkg::MODE_READ,  8'd63,  '1);
        send_word(sav_pkg::MODE_WRITE, 8'd0,   '1);
        send_word(sav_pkg::MODE_READ,  8'd0,   '0);
        send_word(sav_pkg::MODE_WRITE, 8'd63,  64'hA5A5_5A5A_C3C3_3C3C);
        send_word(sav_pkg::MODE_READ,  8'd63,  '0);
        send_word(sav_pkg::MODE_WRITE, 8'd64,  '1);
        send_word(sav_pkg::MODE_READ,  8'd64,  '0);
        send_word(sav_pkg::MODE_FREE,  8'd64,  '0);
        send_word(sav_pkg::MODE_WRITE, 8'd255, '1);
        send_word(sav_pkg::MODE_READ,  8'd255, '0);
        send_word(sav_pkg::MODE_FREE,  8'd255, '0);
        send_word(sav_pkg::MODE_ALLOC, 8'd200, '1);
        send_word(sav_pkg::MODE_ALLOC, 8'd0,   '0);
        send_word(sav_pkg::MODE_ALLOC, 8'd5,   '0);
        send_word(sav_pkg::MODE_FREE,  8'd2,   '0);
        send_word(sav_pkg::MODE_FREE,  8'd2,   '0);
        send_word(sav_pkg::MODE_FREE,  8'd0,   '0);
        send_word(sav_pkg::MODE_ALLOC, 8'd0,   '0);
        send_word(sav_pkg::MODE_WRITE, 8'd1,   64'h8000_0000_0000_0001);
        send_word(sav_pkg::MODE_FREE,  8'd1,   '0);
        send_word(sav_pkg::MODE_READ,  8'd1,   '0);
        send_word(sav_pkg::MODE_READ,  8'd40,  '0);
        send_word(sav_pkg::MODE_ALLOC, 8'd0,   '0);

        for (int phase = 0; phase < 4; phase++) begin
            while (words_sent < (phase + 1) * 325) begin
                gap_percent = ($urandom_range(0, 3) == 0) ? 0 : phase_gap[phase];
                case ($urandom_range(0, 2))
                    0: send_burst(80, 5, 5, $urandom_range(40, 90));
                    1: send_burst(15, 55, 15, $urandom_range(20, 70));
                    default: send_burst(25, 25, 25, $urandom_range(20, 60));
                endcase
            end
        end
        start <= 1'b0;

        do @(posedge i_clk); while (words_pending != 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && words_pending == 0) begin
            $display("PASS slot_allocator_value_store_top");
        end else begin
            $display("FAIL slot_allocator_value_store_top");
        end
        $finish;
    end

endmodule

### sim.f
src/sav_pkg.sv
src/sav_ctrl.sv
src/sav_dpath.sv
src/slot_allocator_value_store_top.sv
tb/sv/slot_allocator_value_store_checker.sv
tb/sv/testbench.sv
